// ----- sv/tbwpr_pkg.sv -----
// ----------------------------------------------------------------------------
// tbwpr_pkg
// Shared constants and types for the three-band peak/RMS block.
// ----------------------------------------------------------------------------
package tbwpr_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_WINDOW_DEF  = 4096;
    localparam int COEF_BITS_DEF   = 16;

    localparam int STATE_BITS = 20;
    localparam int SUM_BITS   = 48;
    localparam int WIN_BITS   = 20;
    localparam int CFG_BITS   = 17;
    localparam int LEN_BITS   = 13;
    localparam int ADDR_BITS  = 4;

    localparam logic [ADDR_BITS-1:0] REG_LOW    = 4'h0;
    localparam logic [ADDR_BITS-1:0] REG_HIGH   = 4'h4;
    localparam logic [ADDR_BITS-1:0] REG_LEN    = 4'h8;
    localparam logic [ADDR_BITS-1:0] REG_STEREO = 4'hC;

    // square-root/divide unit control
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } unit_ctl_t;

endpackage

// ----- sv/three_band_window_peak_rms_core.sv -----
// ----------------------------------------------------------------------------
// three_band_window_peak_rms_core
// Three-band split with windowed peak and per-band RMS.
// ----------------------------------------------------------------------------
// Input stream s_axis: one word per audio frame (left, right samples).
// Output stream m_axis: one word at the close of each window carrying the
// peak, bass/mid/treble RMS and the window index.
// APB port sets the two coefficients, window length and stereo mode.
// A frame passes through the shared multiplier/adder sequencer in the
// steps accept, four filter poles, three squares and window check. A frame
// that closes a window adds three RMS runs on the shared divide/root unit
// (each: start, 48 divide steps, root steps, done) and an output step, and
// then returns to idle once the output register can take the result.
// s_axis_tready is high only in the idle state. The result sits in an
// output register; a stalled receiver holds it, and new frames are still
// taken while it waits unless another result is due, which then waits.
// Reset clears filter states, sums, counters and registers (window length 1).
// ----------------------------------------------------------------------------
module three_band_window_peak_rms_core
    import tbwpr_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [2*SAMPLE_BITS-1:0] s_axis_tdata,   // left_sample, right_sample
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [87:0]              m_axis_tdata,   // peak, bass, mid, treble, window_index
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [tbwpr_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int CNT_BITS = $clog2(MAX_WINDOW) + 1;
    localparam int MW       = SAMPLE_BITS + 8;

    typedef enum logic [11:0]
    {
        S_IDLE  = 12'b000000000001,
        S_B1    = 12'b000000000010,
        S_B2    = 12'b000000000100,
        S_T1    = 12'b000000001000,
        S_T2    = 12'b000000010000,
        S_SQB   = 12'b000000100000,
        S_SQM   = 12'b000001000000,
        S_SQT   = 12'b000010000000,
        S_CHK   = 12'b000100000000,
        S_RMS   = 12'b001000000000,
        S_WAIT  = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CFG_BITS-1:0]    low_reg, high_reg;
    logic [LEN_BITS-1:0]    len_reg;
    logic                   stereo_reg;
    logic signed [STATE_BITS-1:0] b1_reg, b2_reg, t1_reg, t2_reg;
    logic signed [STATE_BITS-1:0] x_reg, hp_reg;
    logic [SAMPLE_BITS:0]   peak_reg;
    logic [SUM_BITS-1:0]    sb_reg, sm_reg, st_reg;
    logic [CNT_BITS-1:0]    frames_reg;
    logic [WIN_BITS-1:0]    win_reg;
    logic [1:0]             rsel_reg;
    logic [15:0]            rb_reg, rm_reg, rt_reg;
    logic                   ovalid_reg;
    logic [87:0]            odata_reg;

    logic signed [SAMPLE_BITS-1:0] ls, rs;
    logic signed [SAMPLE_BITS:0]   mix;
    logic [SAMPLE_BITS:0]          mag;
    logic [COEF_BITS:0]            al, ah, acoef;
    logic signed [STATE_BITS-1:0]  ps, px, pn;
    logic signed [STATE_BITS+1:0]  diff;
    logic signed [STATE_BITS+COEF_BITS+3:0] prod;
    logic signed [STATE_BITS+2:0]  dsum;
    logic signed [STATE_BITS+1:0]  sq_in;
    logic [STATE_BITS+1:0]         sq_mag;
    logic [2*STATE_BITS+3:0]       sq;
    logic [SUM_BITS-1:0]           acc, acc_new;
    logic [SUM_BITS:0]             acc_sum;
    logic signed [STATE_BITS+1:0]  treb, mid;
    logic [CNT_BITS-1:0]           len_eff;
    logic                          wr, uni_start, uni_done;
    logic [15:0]                   uni_root;
    logic [SUM_BITS-1:0]           uni_sum;

    assign ls  = s_axis_tdata[SAMPLE_BITS-1:0];
    assign rs  = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign mix = stereo_reg ? ((SAMPLE_BITS+1)'(ls) + (SAMPLE_BITS+1)'(rs)) >>> 1
                            : (SAMPLE_BITS+1)'(ls);
    assign al  = (low_reg  > CFG_BITS'(1 << COEF_BITS)) ? (COEF_BITS+1)'(1 << COEF_BITS)
                                                          : (COEF_BITS+1)'(low_reg);
    assign ah  = (high_reg > CFG_BITS'(1 << COEF_BITS)) ? (COEF_BITS+1)'(1 << COEF_BITS)
                                                          : (COEF_BITS+1)'(high_reg);

    // shared one-pole update
    always_comb
    begin
        ps    = b1_reg;
        px    = x_reg;
        acoef = al;
        case (state_reg)
            S_B2:    begin ps = b2_reg; px = b1_reg; end
            S_T1:    begin ps = t1_reg; acoef = ah; end
            S_T2:    begin ps = t2_reg; px = hp_reg; acoef = ah; end
            default: ;
        endcase
        diff = (STATE_BITS+2)'(px) - (STATE_BITS+2)'(ps);
        prod = $signed({1'b0, acoef}) * diff
             + (STATE_BITS+COEF_BITS+4)'(1 << (COEF_BITS-1));
        dsum = (STATE_BITS+3)'(ps) + (STATE_BITS+3)'(prod >>> COEF_BITS);
        if (dsum > (STATE_BITS+3)'(524287))
            pn = STATE_BITS'(524287);
        else if (dsum < -(STATE_BITS+3)'(524288))
            pn = -STATE_BITS'(524288);
        else
            pn = STATE_BITS'(dsum);
    end

    // shared square-accumulate
    assign treb = (STATE_BITS+2)'(hp_reg) - (STATE_BITS+2)'(t2_reg);
    assign mid  = (STATE_BITS+2)'(x_reg) - (STATE_BITS+2)'(b2_reg) - treb;
    always_comb
    begin
        sq_in = (STATE_BITS+2)'(b2_reg);
        acc   = sb_reg;
        case (state_reg)
            S_SQM:   begin sq_in = mid;  acc = sm_reg; end
            S_SQT:   begin sq_in = treb; acc = st_reg; end
            default: ;
        endcase
        sq_mag  = sq_in[STATE_BITS+1] ? -sq_in : sq_in;
        sq      = sq_mag * sq_mag;
        acc_sum = {1'b0, acc} + (SUM_BITS+1)'(sq);
        acc_new = acc_sum[SUM_BITS] ? '1 : acc_sum[SUM_BITS-1:0];
    end

    assign mag = mix[SAMPLE_BITS] ? -mix : mix;
    always_comb
    begin
        if (len_reg == '0)
            len_eff = CNT_BITS'(1);
        else if (32'(len_reg) > MAX_WINDOW)
            len_eff = CNT_BITS'(MAX_WINDOW);
        else
            len_eff = CNT_BITS'(len_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_axis_tvalid) state_next = S_B1;
            S_B1:    state_next = S_B2;
            S_B2:    state_next = S_T1;
            S_T1:    state_next = S_T2;
            S_T2:    state_next = S_SQB;
            S_SQB:   state_next = S_SQM;
            S_SQM:   state_next = S_SQT;
            S_SQT:   state_next = S_CHK;
            S_CHK:   state_next = (frames_reg >= len_eff) ? S_RMS : S_IDLE;
            S_RMS:   state_next = S_WAIT;
            S_WAIT:  if (uni_done) state_next = (rsel_reg == 2'd2) ? S_OUT : S_RMS;
            S_OUT:   if (!ovalid_reg || m_axis_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign uni_start = (state_reg == S_RMS);
    assign uni_sum   = (rsel_reg == 2'd0) ? sb_reg : (rsel_reg == 2'd1) ? sm_reg : st_reg;

    tbwpr_rms_unit #(.CNT_BITS(CNT_BITS)) u_rms
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (uni_start),
        .sum   (uni_sum),
        .count (frames_reg),
        .done  (uni_done),
        .root  (uni_root)
    );

    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            low_reg    <= '0;
            high_reg   <= '0;
            len_reg    <= LEN_BITS'(1);
            stereo_reg <= 1'b0;
            b1_reg     <= '0;
            b2_reg     <= '0;
            t1_reg     <= '0;
            t2_reg     <= '0;
            peak_reg   <= '0;
            sb_reg     <= '0;
            sm_reg     <= '0;
            st_reg     <= '0;
            frames_reg <= '0;
            win_reg    <= '0;
            rsel_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr)
            begin
                case (paddr)
                    REG_LOW:    low_reg    <= pwdata[CFG_BITS-1:0];
                    REG_HIGH:   high_reg   <= pwdata[CFG_BITS-1:0];
                    REG_LEN:    len_reg    <= pwdata[LEN_BITS-1:0];
                    REG_STEREO: stereo_reg <= pwdata[0];
                    default:    ;
                endcase
            end
            if (state_reg == S_OUT && (!ovalid_reg || m_axis_tready))
                ovalid_reg <= 1'b1;
            else if (ovalid_reg && m_axis_tready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        if (mag > peak_reg)
                            peak_reg <= mag;
                        frames_reg <= frames_reg + CNT_BITS'(1);
                        rsel_reg   <= '0;
                    end
                end
                S_B1: b1_reg <= pn;
                S_B2: b2_reg <= pn;
                S_T1: t1_reg <= pn;
                S_T2: t2_reg <= pn;
                S_SQB: sb_reg <= acc_new;
                S_SQM: sm_reg <= acc_new;
                S_SQT: st_reg <= acc_new;
                S_WAIT: if (uni_done) rsel_reg <= rsel_reg + 2'd1;
                S_OUT:
                begin
                    if (!ovalid_reg || m_axis_tready)
                    begin
                        win_reg    <= win_reg + WIN_BITS'(1);
                        peak_reg   <= '0;
                        sb_reg     <= '0;
                        sm_reg     <= '0;
                        st_reg     <= '0;
                        frames_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_axis_tvalid)
            x_reg <= STATE_BITS'(mix);
        if (state_reg == S_T1)
            hp_reg <= x_reg - pn;
        if (state_reg == S_WAIT && uni_done)
        begin
            case (rsel_reg)
                2'd0:    rb_reg <= uni_root;
                2'd1:    rm_reg <= uni_root;
                default: rt_reg <= uni_root;
            endcase
        end
        if (state_reg == S_OUT && (!ovalid_reg || m_axis_tready))
            odata_reg <= {4'b0, win_reg, rt_reg, rm_reg, rb_reg, 16'(peak_reg)};
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign pready        = 1'b1;

    always_comb
    begin
        case (paddr)
            REG_LOW:    prdata = 32'(low_reg);
            REG_HIGH:   prdata = 32'(high_reg);
            REG_LEN:    prdata = 32'(len_reg);
            REG_STEREO: prdata = 32'(stereo_reg);
            default:    prdata = '0;
        endcase
    end

endmodule

// ----- sv/tbwpr_rms_unit.sv -----
// ----------------------------------------------------------------------------
// tbwpr_rms_unit
// Iterative floor(sqrt(floor(sum / count))) saturated to 16 bits.
// Restoring divide (one quotient bit per cycle), then one root bit per cycle.
// ----------------------------------------------------------------------------
module tbwpr_rms_unit
    import tbwpr_pkg::*;
#(
    parameter int CNT_BITS = 17
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SUM_BITS-1:0] sum,
    input  logic [CNT_BITS-1:0] count,
    output logic                done,
    output logic [15:0]         root
);

    typedef enum logic [3:0]
    {
        U_IDLE = 4'b0001,
        U_DIV  = 4'b0010,
        U_SQRT = 4'b0100,
        U_DONE = 4'b1000
    } ustate_t;

    ustate_t              state_reg, state_next;
    logic [SUM_BITS-1:0]  q_reg, q_next;
    logic [CNT_BITS:0]    rem_reg, rem_next;
    logic [CNT_BITS-1:0]  den_reg, den_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic [SUM_BITS-1:0]  v_reg, v_next;
    logic [SUM_BITS-1:0]  r_reg, r_next;
    logic [SUM_BITS-1:0]  bit_reg, bit_next;
    logic [CNT_BITS:0]    shl;
    logic [SUM_BITS-1:0]  rb;

    always_comb
    begin
        state_next = state_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        cnt_next   = cnt_reg;
        v_next     = v_reg;
        r_next     = r_reg;
        bit_next   = bit_reg;
        shl        = {rem_reg[CNT_BITS-1:0], q_reg[SUM_BITS-1]};
        rb         = r_reg + bit_reg;
        case (state_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    q_next     = sum;
                    rem_next   = '0;
                    den_next   = count;
                    cnt_next   = 6'(SUM_BITS - 1);
                    state_next = U_DIV;
                end
            end
            U_DIV:
            begin
                q_next = {q_reg[SUM_BITS-2:0], 1'b0};
                if (shl >= {1'b0, den_reg})
                begin
                    rem_next  = shl - {1'b0, den_reg};
                    q_next[0] = 1'b1;
                end
                else
                begin
                    rem_next = shl;
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    v_next     = q_next;
                    r_next     = '0;
                    bit_next   = SUM_BITS'(1) << (SUM_BITS - 2);
                    state_next = U_SQRT;
                end
            end
            U_SQRT:
            begin
                if (bit_reg == '0)
                begin
                    state_next = U_DONE;
                end
                else
                begin
                    if (v_reg >= rb)
                    begin
                        v_next = v_reg - rb;
                        r_next = (r_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        r_next = r_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
            end
            U_DONE:
            begin
                state_next = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        v_reg   <= v_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign done = (state_reg == U_DONE);
    assign root = (r_reg > SUM_BITS'(16'hFFFF)) ? 16'hFFFF : r_reg[15:0];

endmodule

// ----- sv/tbwpr_checker.sv -----
// ----------------------------------------------------------------------------
// tbwpr_checker
// Port-level checks for the three-band peak/RMS block.
// ----------------------------------------------------------------------------
module tbwpr_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [87:0] m_axis_tdata,
    input  logic        pready
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted back to back");

    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:0] <= 16'h8000)
        else $error("peak out of range");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind three_band_window_peak_rms_core tbwpr_checker u_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);

// ----- tb/sv/three_band_window_peak_rms_core_tb.sv -----
// ----------------------------------------------------------------------------
// three_band_window_peak_rms_core_tb
// Streams audio frames through the three-band peak/RMS core under several
// register settings, with random idling on both streams and one long output
// stall, and checks every window result against an in-bench predictor.
// ----------------------------------------------------------------------------
module three_band_window_peak_rms_core_tb;
    import tbwpr_pkg::*;

    typedef struct packed {
        logic [19:0] window_index;
        logic [15:0] treble_rms;
        logic [15:0] mid_rms;
        logic [15:0] bass_rms;
        logic [15:0] peak_level;
    } window_result_t;

    class band_meter_scoreboard;
        logic [16:0] low_coef;
        logic [16:0] high_coef;
        logic [12:0] win_len;
        logic        stereo;
        longint bass_a, bass_b, treb_a, treb_b;
        longint peak, bass_sum, mid_sum, treb_sum;
        int unsigned frames;
        logic [19:0] win_count;
        window_result_t expected_windows[$];
        int errors;

        function new();
            low_coef = 0;
            high_coef = 0;
            win_len = 1;
            stereo = 0;
            bass_a = 0;
            bass_b = 0;
            treb_a = 0;
            treb_b = 0;
            peak = 0;
            bass_sum = 0;
            mid_sum = 0;
            treb_sum = 0;
            frames = 0;
            win_count = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [ADDR_BITS-1:0] addr, logic [31:0] val);
            case (addr)
                REG_LOW:    low_coef = val[16:0];
                REG_HIGH:   high_coef = val[16:0];
                REG_LEN:    win_len = val[12:0];
                REG_STEREO: stereo = val[0];
                default: ;
            endcase
        endfunction

        function longint one_pole(longint s, longint x, longint a);
            longint n;
            n = s + ((a * (x - s) + 32768) >>> 16);
            if (n > 524287) n = 524287;
            if (n < -524288) n = -524288;
            return n;
        endfunction

        function longint sq_acc(longint sum, longint v);
            longint r;
            r = sum + v * v;
            if (r > 64'hFFFF_FFFF_FFFF) r = 64'hFFFF_FFFF_FFFF;
            return r;
        endfunction

        function logic [15:0] band_rms(longint sum);
            longint q, r;
            q = sum / frames;
            r = 0;
            for (int b = 24; b >= 0; b--)
                if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= q)
                    r = r | (64'd1 << b);
            return (r > 65535) ? 16'hFFFF : r[15:0];
        endfunction

        function void note_frame(logic signed [15:0] left, logic signed [15:0] right);
            longint v, al, ah, hp, bass, treb, mid, mag;
            int unsigned len;
            window_result_t w;
            v = stereo ? ((longint'(left) + longint'(right)) >>> 1) : longint'(left);
            al = (low_coef > 65536) ? 65536 : longint'(low_coef);
            ah = (high_coef > 65536) ? 65536 : longint'(high_coef);
            mag = v < 0 ? -v : v;
            bass_a = one_pole(bass_a, v, al);
            bass_b = one_pole(bass_b, bass_a, al);
            treb_a = one_pole(treb_a, v, ah);
            hp = v - treb_a;
            treb_b = one_pole(treb_b, hp, ah);
            bass = bass_b;
            treb = hp - treb_b;
            mid = v - bass - treb;
            if (mag > peak) peak = mag;
            bass_sum = sq_acc(bass_sum, bass);
            mid_sum = sq_acc(mid_sum, mid);
            treb_sum = sq_acc(treb_sum, treb);
            frames++;
            len = 32'(win_len);
            if (len == 0) len = 1;
            if (len > 4096) len = 4096;
            if (frames < len) return;
            w.peak_level = peak[15:0];
            w.bass_rms = band_rms(bass_sum);
            w.mid_rms = band_rms(mid_sum);
            w.treble_rms = band_rms(treb_sum);
            w.window_index = win_count;
            expected_windows.push_back(w);
            win_count++;
            peak = 0;
            bass_sum = 0;
            mid_sum = 0;
            treb_sum = 0;
            frames = 0;
        endfunction

        function void check_result(logic [87:0] data);
            window_result_t got, exp_w;
            got = data[83:0];
            if (expected_windows.size() == 0) begin
                $error("unexpected result word %h", data);
                errors++;
                return;
            end
            exp_w = expected_windows.pop_front();
            if (got.peak_level !== exp_w.peak_level) begin
                $error("peak_level exp %0d got %0d", exp_w.peak_level, got.peak_level);
                errors++;
            end
            if (got.bass_rms !== exp_w.bass_rms) begin
                $error("bass_rms exp %0d got %0d", exp_w.bass_rms, got.bass_rms);
                errors++;
            end
            if (got.mid_rms !== exp_w.mid_rms) begin
                $error("mid_rms exp %0d got %0d", exp_w.mid_rms, got.mid_rms);
                errors++;
            end
            if (got.treble_rms !== exp_w.treble_rms) begin
                $error("treble_rms exp %0d got %0d", exp_w.treble_rms, got.treble_rms);
                errors++;
            end
            if (got.window_index !== exp_w.window_index) begin
                $error("window_index exp %0d got %0d", exp_w.window_index, got.window_index);
                errors++;
            end
        endfunction
    endclass

    logic                 clk = 0;
    logic                 rst_n = 0;
    logic                 s_axis_tvalid = 0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata = '0;   // left_sample, right_sample
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 0;
    logic [87:0]          m_axis_tdata;        // peak, bass, mid, treble, window_index
    logic                 psel = 0;
    logic                 penable = 0;
    logic                 pwrite = 0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    band_meter_scoreboard sb = new();
    bit quiet = 0;
    bit hold_req = 0;
    int idle_cycles = 0;
    logic signed [15:0] walk_l, walk_r;

    three_band_window_peak_rms_core u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        if (rst_n && ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 6000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        forever begin
            if (hold_req) begin
                m_axis_tready <= 0;
                repeat (1500) @(posedge clk);
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end else begin
                m_axis_tready <= 1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    task automatic apb_write(logic [ADDR_BITS-1:0] addr, logic [31:0] val);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= addr;
        pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        sb.write_reg(addr, val);
    endtask

    task automatic set_regs(logic [16:0] lo, logic [16:0] hi, logic [12:0] len, logic st);
        apb_write(REG_LOW, 32'(lo));
        apb_write(REG_HIGH, 32'(hi));
        apb_write(REG_LEN, 32'(len));
        apb_write(REG_STEREO, 32'(st));
    endtask

    task automatic send_frame(logic [15:0] left, logic [15:0] right);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {right, left};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_frame(left, right);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.expected_windows.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_sample(ref logic signed [15:0] walk);
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 65535));
            default: begin
                walk = walk + $signed(16'($urandom_range(0, 4095)) - 16'sd2048);
                return walk;
            end
        endcase
    endfunction

    function automatic logic [16:0] pick_coef();
        case ($urandom_range(0, 4))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'h1FFFF;
            3: return 17'($urandom_range(0, 65536));
            default: return 17'($urandom_range(0, 131071));
        endcase
    endfunction

    function automatic logic [12:0] pick_len();
        case ($urandom_range(0, 5))
            0: return 13'd0;
            1: return 13'd1;
            2: return 13'($urandom_range(1, 40));
            default: return 13'($urandom_range(2, 8));
        endcase
    endfunction

    task automatic random_phase(int count);
        repeat (count) send_frame(pick_sample(walk_l), pick_sample(walk_r));
        drain();
    endtask

    initial begin
        logic [15:0] edge_vals[5];
        edge_vals = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};
        walk_l = 0;
        walk_r = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        set_regs(17'd65536, 17'h1FFFF, 13'd1, 1'b0);
        foreach (edge_vals[i]) send_frame(edge_vals[i], edge_vals[4 - i]);
        drain();
        set_regs(17'd0, 17'd65536, 13'd0, 1'b1);
        foreach (edge_vals[i]) send_frame(edge_vals[i], edge_vals[i]);
        send_frame(16'h8000, 16'h7FFF);
        send_frame(16'h7FFF, 16'h8000);
        drain();
        set_regs(17'd9000, 17'd40000, 13'd3, 1'b1);
        repeat (10) send_frame(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        drain();

        for (int p = 0; p < 10; p++) begin
            set_regs(pick_coef(), pick_coef(), pick_len(), 1'($urandom_range(0, 1)));
            random_phase($urandom_range(40, 110));
        end

        // output held off while frames keep coming
        set_regs(17'd2000, 17'd30000, 13'd1, 1'b0);
        hold_req = 1;
        random_phase(40);

        set_regs(pick_coef(), pick_coef(), 13'h1FFF, 1'b1);
        random_phase(90);
        set_regs(17'd500, 17'd20000, 13'd50, 1'b0);
        random_phase(90);

        quiet = 1;
        set_regs(pick_coef(), pick_coef(), 13'd5, 1'b1);
        random_phase(100);

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
